// File: rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared constants and helpers for the compensated double accumulator.
// ----------------------------------------------------------------------------
package cda_pkg;

	localparam int unsigned FpW    = 64;
	localparam int unsigned ExpW   = 11;
	localparam int unsigned FracW  = 52;
	localparam int unsigned ManW   = FracW + 1;
	localparam int unsigned WorkW  = ManW + 3;  // mantissa plus guard, round, sticky

	localparam logic [FpW-1:0]  QNAN     = 64'h7FF8_0000_0000_0000;
	localparam logic [FpW-1:0]  POS_ZERO = 64'h0000_0000_0000_0000;
	localparam logic [ExpW-1:0] EXP_MAX  = 11'h7FF;

	function automatic logic is_nan(input logic [FpW-1:0] v);
		is_nan = (v[62:52] == EXP_MAX) && (v[51:0] != '0);
	endfunction

	// leading zero count of the working mantissa
	function automatic logic [5:0] lzc(input logic [WorkW-1:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'(WorkW);
		found = 1'b0;
		for (int i = WorkW - 1; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(WorkW - 1 - i);
				found = 1'b1;
			end
		end
		lzc = n;
	endfunction

endpackage

// File: rtl/compensated_double_accumulator.sv
// ----------------------------------------------------------------------------
// compensated_double_accumulator
// Streaming binary64 Neumaier compensated accumulator.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | addend[63:0], restart
//  output  | out_valid / out_ready| running_total, compensation_out,
//          |                      | corrected_total
//
// One item per cycle sustained unless the output stalls; each item passes the
// input register, then the result register. The whole update, a chain of five
// binary64 adds, sits between those registers, and the sum/compensation
// feedback closes in it. Reset clears both accumulators to +0 and empties both
// stages. A stalled output holds the result; the input register still takes
// an item when the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
module compensated_double_accumulator
	import cda_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [FpW-1:0] addend,
	input  logic           restart,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [FpW-1:0] running_total,
	output logic [FpW-1:0] compensation_out,
	output logic [FpW-1:0] corrected_total
);

	logic           valid_s1;
	logic [FpW-1:0] addend_s1;
	logic           restart_s1;
	logic [FpW-1:0] sum_q, comp_q;
	logic [FpW-1:0] s_in, c_in, t_w, c_w, tot_w;
	logic           adv;

	// stage 1 moves on whenever the result register is free or being drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = !valid_s1 || adv;

	// restart clears the accumulators ahead of this item's add
	assign s_in = restart_s1 ? POS_ZERO : sum_q;
	assign c_in = restart_s1 ? POS_ZERO : comp_q;

	cda_step u_step (
		.s     (s_in),
		.c     (c_in),
		.x     (addend_s1),
		.t     (t_w),
		.c_new (c_w),
		.total (tot_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
			sum_q     <= POS_ZERO;
			comp_q    <= POS_ZERO;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid <= valid_s1;
				if (valid_s1) begin
					sum_q  <= t_w;
					comp_q <= c_w;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			addend_s1  <= addend;
			restart_s1 <= restart;
		end
		if (adv && valid_s1) begin
			running_total    <= t_w;
			compensation_out <= c_w;
			corrected_total  <= tot_w;
		end
	end

	// accumulators only move when an item is retired into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && valid_s1) |=> $stable(sum_q) && $stable(comp_q))
		else $error("accumulator changed without a retiring item");

	// the shown running total is always the stored sum
	a_total_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> running_total == sum_q && compensation_out == comp_q)
		else $error("result out of step with accumulator state");

	// NaN results leave in canonical form
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && corrected_total[62:52] == EXP_MAX && corrected_total[51:0] != '0
		|-> corrected_total == QNAN)
		else $error("non-canonical NaN on corrected total");

endmodule

// File: rtl/cda_fp_add.sv
// ----------------------------------------------------------------------------
// cda_fp_add
// Combinational binary64 adder, round to nearest even, canonical NaN out.
// ----------------------------------------------------------------------------
module cda_fp_add
	import cda_pkg::*;
(
	input  logic [FpW-1:0] a,
	input  logic [FpW-1:0] b,
	output logic [FpW-1:0] y
);

	logic              a_big;
	logic [FpW-1:0]    big, sml;
	logic [ManW-1:0]   m_big, m_sml;
	logic [12:0]       e_big, e_sml, d;
	logic [WorkW+57:0] wide;
	logic [WorkW-1:0]  al_sml, w_big;
	logic [WorkW:0]    r;
	logic [WorkW-1:0]  n;
	logic [12:0]       e_n;
	logic [5:0]        lz, shamt;
	logic [ManW:0]     rnd;
	logic [12:0]       e_r;
	logic              g, rest, up, eff_sub;

	always_comb begin
		a_big = a[62:0] >= b[62:0];
		big   = a_big ? a : b;
		sml   = a_big ? b : a;
		m_big = {big[62:52] != '0, big[51:0]};
		m_sml = {sml[62:52] != '0, sml[51:0]};
		e_big = (big[62:52] == '0) ? 13'd1 : {2'b0, big[62:52]};
		e_sml = (sml[62:52] == '0) ? 13'd1 : {2'b0, sml[62:52]};
		d     = e_big - e_sml;
		eff_sub = a[63] ^ b[63];
		w_big = {m_big, 3'b000};
		wide  = '0;
		if (d > 13'd58) begin
			al_sml = {55'b0, m_sml != '0};
		end else begin
			wide   = {m_sml, 3'b000, 58'b0} >> d;
			al_sml = {wide[113:59], wide[58] | (wide[57:0] != '0)};
		end
		r = eff_sub ? ({1'b0, w_big} - {1'b0, al_sml}) : ({1'b0, w_big} + {1'b0, al_sml});

		lz    = lzc(r[WorkW-1:0]);
		shamt = '0;
		if (r[WorkW]) begin
			n   = {r[WorkW:2], r[1] | r[0]};
			e_n = e_big + 13'd1;
		end else begin
			shamt = ({7'b0, lz} < e_big) ? lz : 6'(e_big - 13'd1);
			n     = r[WorkW-1:0] << shamt;
			e_n   = e_big - {7'b0, shamt};
		end
		g    = n[2];
		rest = n[1] | n[0];
		up   = g & (rest | n[3]);
		rnd  = {1'b0, n[WorkW-1:3]} + {{ManW{1'b0}}, up};
		e_r  = e_n;
		if (rnd[ManW]) begin
			rnd = rnd >> 1;
			e_r = e_n + 13'd1;
		end

		if (is_nan(a) || is_nan(b)) begin
			y = QNAN;
		end else if (a[62:52] == EXP_MAX && b[62:52] == EXP_MAX) begin
			y = eff_sub ? QNAN : a;
		end else if (a[62:52] == EXP_MAX) begin
			y = a;
		end else if (b[62:52] == EXP_MAX) begin
			y = b;
		end else if (r == '0) begin
			y = {a[63] & b[63], 63'b0};
		end else if (e_r >= 13'd2047) begin
			y = {big[63], EXP_MAX, 52'b0};
		end else begin
			y = {big[63], rnd[52] ? e_r[10:0] : 11'b0, rnd[51:0]};
		end
	end

endmodule

// File: rtl/cda_step.sv
// ----------------------------------------------------------------------------
// cda_step
// One Neumaier update: new sum, new compensation and corrected total.
// ----------------------------------------------------------------------------
module cda_step
	import cda_pkg::*;
(
	input  logic [FpW-1:0] s,
	input  logic [FpW-1:0] c,
	input  logic [FpW-1:0] x,
	output logic [FpW-1:0] t,
	output logic [FpW-1:0] c_new,
	output logic [FpW-1:0] total
);

	logic           s_ge;
	logic [FpW-1:0] big, sml, t_neg, diff, err;

	// NaN on either side makes the compare false
	assign s_ge  = !is_nan(s) && !is_nan(x) && (s[62:0] >= x[62:0]);
	assign big   = s_ge ? s : x;
	assign sml   = s_ge ? x : s;
	assign t_neg = {~t[63], t[62:0]};

	cda_fp_add u_t    (.a(s),    .b(x),     .y(t));
	cda_fp_add u_diff (.a(big),  .b(t_neg), .y(diff));
	cda_fp_add u_err  (.a(diff), .b(sml),   .y(err));
	cda_fp_add u_comp (.a(c),    .b(err),   .y(c_new));
	cda_fp_add u_tot  (.a(t),    .b(c_new), .y(total));

endmodule
